// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, status codes and control types for the bitmap block
// allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS  = 64;
    localparam int MAX_REQUEST = 16;

    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int REQ_W   = 5;
    localparam int BIDX_W  = 8;
    localparam int GIDX_W  = 6;
    localparam int FTOT_W  = 7;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = 10;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic load;
        logic single;
        logic grant;
    } bba_cmd_t;

    typedef struct packed {
        logic alloc_ok;
        logic rem_one;
        logic slot_free;
    } bba_stat_t;

endpackage

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: accepts a request, issues a single result or one grant per
// cycle while the output register has room, until the request is satisfied.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_GRANT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.slot_free)
                begin
                    if (stat.alloc_ok)
                    begin
                        cmd.grant  = 1'b1;
                        state_next = stat.rem_one ? S_IDLE : S_GRANT;
                    end
                    else
                    begin
                        cmd.single = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_GRANT:
            begin
                if (stat.slot_free)
                begin
                    cmd.grant = 1'b1;
                    if (stat.rem_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: free map, free counter, request registers, find-first-free
// encoder and the output register.
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bba_pkg::bba_cmd_t            cmd,
    output bba_pkg::bba_stat_t           stat,
    input  logic                         kind,
    input  logic [bba_pkg::REQ_W-1:0]    block_count,
    input  logic [bba_pkg::BIDX_W-1:0]   block_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bba_pkg::STAT_W-1:0]   status,
    output logic [bba_pkg::GIDX_W-1:0]   granted_index,
    output logic                         last,
    output logic [bba_pkg::FTOT_W-1:0]   free_total,
    output logic [bba_pkg::NUM_BLOCKS-1:0] map_view,
    output logic [bba_pkg::CNT_W-1:0]    cnt_view
);

    localparam int NB   = bba_pkg::NUM_BLOCKS;
    localparam int IW   = bba_pkg::IDX_W;
    localparam int CW   = bba_pkg::CNT_W;
    localparam int GW   = bba_pkg::GIDX_W;
    localparam int FW   = bba_pkg::FTOT_W;
    localparam int CMPW = bba_pkg::CMP_W;
    localparam int GXW  = GW + IW;
    localparam int FXW  = FW + CW;

    logic [NB-1:0]               map_reg;
    logic [NB-1:0]               map_next;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic                        kind_reg;
    logic [bba_pkg::REQ_W-1:0]   rem_reg;
    logic [bba_pkg::BIDX_W-1:0]  bidx_reg;

    logic                        out_valid_reg;
    logic [bba_pkg::STAT_W-1:0]  status_reg;
    logic [bba_pkg::STAT_W-1:0]  status_next;
    logic [GW-1:0]               gidx_reg;
    logic [GW-1:0]               gidx_next;
    logic                        last_reg;
    logic                        last_next;
    logic [FW-1:0]               ftot_reg;

    logic [IW-1:0]               ffs_idx;
    logic                        in_range;
    logic [IW-1:0]               rel_idx;
    logic                        alloc_ok;
    logic [GXW-1:0]              gidx_wide;
    logic [FXW-1:0]              ftot_wide;

    always_comb
    begin
        ffs_idx = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                ffs_idx = IW'(i);
            end
        end
    end

    assign in_range = (CMPW'(bidx_reg) < CMPW'(NB));
    assign rel_idx  = bidx_reg[IW-1:0];
    assign alloc_ok = (kind_reg == bba_pkg::KIND_ALLOC) && (rem_reg != '0)
                      && (CMPW'(rem_reg) <= CMPW'(bba_pkg::MAX_REQUEST))
                      && (CMPW'(rem_reg) <= CMPW'(cnt_reg));

    assign stat.alloc_ok  = alloc_ok;
    assign stat.rem_one   = (rem_reg == bba_pkg::REQ_W'(1));
    assign stat.slot_free = !out_valid_reg || out_ready;

    assign gidx_wide = GXW'(ffs_idx);
    assign ftot_wide = FXW'(cnt_next);

    always_comb
    begin
        map_next    = map_reg;
        cnt_next    = cnt_reg;
        status_next = bba_pkg::ST_OK;
        gidx_next   = '0;
        last_next   = 1'b1;
        if (cmd.grant)
        begin
            map_next[ffs_idx] = 1'b0;
            cnt_next          = cnt_reg - CW'(1);
            gidx_next         = gidx_wide[GW-1:0];
            last_next         = stat.rem_one;
        end
        else if (cmd.single)
        begin
            if (kind_reg == bba_pkg::KIND_FREE)
            begin
                if (!in_range)
                begin
                    status_next = bba_pkg::ST_INVALID;
                end
                else if (!map_reg[rel_idx])
                begin
                    map_next[rel_idx] = 1'b1;
                    cnt_next          = cnt_reg + CW'(1);
                end
            end
            else if (rem_reg == '0)
            begin
                status_next = bba_pkg::ST_EMPTY;
            end
            else
            begin
                status_next = bba_pkg::ST_NO_FREE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '1;
            cnt_reg       <= CW'(NB);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            map_reg <= map_next;
            cnt_reg <= cnt_next;
            if (cmd.grant || cmd.single)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            rem_reg  <= block_count;
            bidx_reg <= block_index;
        end
        else if (cmd.grant)
        begin
            rem_reg <= rem_reg - bba_pkg::REQ_W'(1);
        end
        if (cmd.grant || cmd.single)
        begin
            status_reg <= status_next;
            gidx_reg   <= gidx_next;
            last_reg   <= last_next;
            ftot_reg   <= ftot_wide[FW-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = gidx_reg;
    assign last          = last_reg;
    assign free_total    = ftot_reg;
    assign map_view      = map_reg;
    assign cnt_view      = cnt_reg;

endmodule

// ===== rtl/bitmap_block_allocator_top.sv =====
// Requests are registered on transfer and evaluated in S_EVAL; results are
// registered in the output register. A free, empty or rejected request gives one
// result; an allocate of n blocks gives n, one granted index per cycle from the
// find-first-free encoder over the free map while the output is not stalled.
// Reset: all blocks free, free count at the block count; no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit bitmap block allocator with valid/ready request and result ports.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [bba_pkg::REQ_W-1:0]    block_count,
    input  logic [bba_pkg::BIDX_W-1:0]   block_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bba_pkg::STAT_W-1:0]   status,
    output logic [bba_pkg::GIDX_W-1:0]   granted_index,
    output logic                         last,
    output logic [bba_pkg::FTOT_W-1:0]   free_total
);

    bba_pkg::bba_cmd_t              cmd;
    bba_pkg::bba_stat_t             stat;
    logic [bba_pkg::NUM_BLOCKS-1:0] map_view;
    logic [bba_pkg::CNT_W-1:0]      cnt_view;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .block_count   (block_count),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .last          (last),
        .free_total    (free_total),
        .map_view      (map_view),
        .cnt_view      (cnt_view)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bba_pkg::CMP_W'(cnt_view) <= bba_pkg::CMP_W'(bba_pkg::NUM_BLOCKS))
        else $error("free count above block count");

    a_grant_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (map_view != '0))
        else $error("grant with no free block");

    a_grant_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |=> (cnt_view == $past(cnt_view) - bba_pkg::CNT_W'(1)))
        else $error("grant did not lower free count");

    a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grant || cmd.single) |-> (!out_valid || out_ready))
        else $error("result issued into a full output register");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap block allocator against a behavioral free-map model. A
// directed pass covers empty, oversized and rejected allocates, invalid and
// repeated frees and pool exhaustion. A random pass follows with bursty idle
// cycles on both the request and result channels.
// ----------------------------------------------------------------------------
module testbench;

    class alloc_scoreboard;

        typedef struct {
            logic [bba_pkg::STAT_W-1:0] status;
            logic [bba_pkg::GIDX_W-1:0] granted_index;
            logic                       last;
            logic [bba_pkg::FTOT_W-1:0] free_total;
        } grant_t;

        bit          free_map[bba_pkg::NUM_BLOCKS];
        int unsigned free_cnt;
        grant_t      grant_q[$];
        int          errors;

        function new();
            foreach (free_map[b])
                free_map[b] = 1'b1;
            free_cnt = bba_pkg::NUM_BLOCKS;
            errors   = 0;
        endfunction

        function int pending();
            return grant_q.size();
        endfunction

        function int pick_used(int start);
            int b;
            for (int i = 0; i < bba_pkg::NUM_BLOCKS; i++)
            begin
                b = (start + i) % bba_pkg::NUM_BLOCKS;
                if (!free_map[b])
                    return b;
            end
            return start;
        endfunction

        function void push_result(logic [bba_pkg::STAT_W-1:0] st, int idx, logic lst);
            grant_t g;
            g.status        = st;
            g.granted_index = idx[bba_pkg::GIDX_W-1:0];
            g.last          = lst;
            g.free_total    = free_cnt[bba_pkg::FTOT_W-1:0];
            grant_q.insert(grant_q.size(), g);
        endfunction

        function void note_request(logic k, logic [bba_pkg::REQ_W-1:0] cnt,
                                   logic [bba_pkg::BIDX_W-1:0] idx);
            int granted;
            if (k == bba_pkg::KIND_FREE)
            begin
                if (idx >= bba_pkg::NUM_BLOCKS)
                    push_result(bba_pkg::ST_INVALID, 0, 1'b1);
                else
                begin
                    if (!free_map[idx])
                    begin
                        free_map[idx] = 1'b1;
                        free_cnt++;
                    end
                    push_result(bba_pkg::ST_OK, 0, 1'b1);
                end
            end
            else if (cnt == 0)
                push_result(bba_pkg::ST_EMPTY, 0, 1'b1);
            else if (cnt > bba_pkg::MAX_REQUEST || cnt > free_cnt)
                push_result(bba_pkg::ST_NO_FREE, 0, 1'b1);
            else
            begin
                granted = 0;
                for (int b = 0; b < bba_pkg::NUM_BLOCKS && granted < cnt; b++)
                begin
                    if (free_map[b])
                    begin
                        free_map[b] = 1'b0;
                        free_cnt--;
                        push_result(bba_pkg::ST_OK, b, (granted + 1 == cnt));
                        granted++;
                    end
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_result(logic [bba_pkg::STAT_W-1:0] st,
                          logic [bba_pkg::GIDX_W-1:0] gidx,
                          logic lst, logic [bba_pkg::FTOT_W-1:0] ftot);
            grant_t g;
            if (grant_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d index=%0d",
                                          st, gidx));
                return;
            end
            g = grant_q.pop_front();
            if (st !== g.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, g.status));
            if (gidx !== g.granted_index)
                report_mismatch($sformatf("granted_index %0d, expected %0d",
                                          gidx, g.granted_index));
            if (lst !== g.last)
                report_mismatch($sformatf("last %0b, expected %0b", lst, g.last));
            if (ftot !== g.free_total)
                report_mismatch($sformatf("free_total %0d, expected %0d",
                                          ftot, g.free_total));
        endtask

    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       kind;
    logic [bba_pkg::REQ_W-1:0]  block_count;
    logic [bba_pkg::BIDX_W-1:0] block_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [bba_pkg::STAT_W-1:0] status;
    logic [bba_pkg::GIDX_W-1:0] granted_index;
    logic                       last;
    logic [bba_pkg::FTOT_W-1:0] free_total;

    alloc_scoreboard sb;
    bit              calm;
    int              stall_left;

    bitmap_block_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .block_count   (block_count),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .last          (last),
        .free_total    (free_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // hold ready low in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, granted_index, last, free_total);
    end

    task automatic send_request(input logic k, input int cnt, input int idx);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        block_count <= cnt[bba_pkg::REQ_W-1:0];
        block_index <= idx[bba_pkg::BIDX_W-1:0];
        do
            @(negedge clk);
        while (!in_ready);
        sb.note_request(k, cnt[bba_pkg::REQ_W-1:0], idx[bba_pkg::BIDX_W-1:0]);
        @(posedge clk);
    endtask

    task automatic send_alloc(input int cnt);
        send_request(bba_pkg::KIND_ALLOC, cnt, $urandom_range(0, 255));
    endtask

    task automatic send_free(input int idx);
        send_request(bba_pkg::KIND_FREE, $urandom_range(0, 31), idx);
    endtask

    task automatic run_directed();
        send_alloc(0);
        send_alloc(17);
        send_alloc(31);
        send_free(64);
        send_free(255);
        send_free(0);
        send_alloc(1);
        send_alloc(16);
        send_alloc(16);
        send_alloc(16);
        send_alloc(16);
        send_alloc(15);
        send_alloc(1);
        send_free(63);
        send_free(0);
        send_free(63);
        send_alloc(3);
        send_alloc(2);
        send_free(31);
        send_free(32);
        send_alloc(2);
    endtask

    task automatic run_random(input int n_items);
        int r;
        for (int i = 0; i < n_items; i++)
        begin
            if (i >= n_items - 50)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 4)
                send_alloc(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31));
            else if (r < 10)
                send_free($urandom_range(bba_pkg::NUM_BLOCKS, 255));
            else if (r < 45)
                send_alloc(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, bba_pkg::MAX_REQUEST));
            else if (r < 92)
                send_free(sb.pick_used($urandom_range(0, bba_pkg::NUM_BLOCKS - 1)));
            else
                send_free($urandom_range(0, bba_pkg::NUM_BLOCKS - 1));
        end
    endtask

    initial
    begin
        sb          = new();
        calm        = 1'b0;
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        kind        <= bba_pkg::KIND_ALLOC;
        block_count <= '0;
        block_index <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(400);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
